// File: rtl/cslu_pkg.sv
// shared types and constants of the console serial line unit
package cslu_pkg;

  // bus command carried in the input tuser
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // register select
  typedef enum logic [1:0] {
    REG_RX_STATUS = 2'd0,
    REG_RX_BUFFER = 2'd1,
    REG_TX_STATUS = 2'd2,
    REG_TX_BUFFER = 2'd3
  } reg_t;

  localparam int unsigned CHAR_W       = 7;
  localparam int unsigned DATA_W       = 16;
  localparam int unsigned DELAY_W      = 8;
  localparam int unsigned DONE_BIT     = 7;
  localparam int unsigned INT_EN_BIT   = 6;
  localparam logic [DELAY_W-1:0] TX_DELAY_RESET = 8'd32;

  // one input word after unpacking
  typedef struct packed {
    cmd_t              cmd;
    reg_t              reg_sel;
    logic [DATA_W-1:0] write_data;
    logic              rx_valid;
    logic [7:0]        rx_char;
  } item_t;

  // one result word
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              rx_accepted;
    logic              tx_valid;
    logic [CHAR_W-1:0] tx_char;
    logic              rx_irq;
    logic              tx_irq;
  } result_t;

endpackage

// File: rtl/console_serial_line_unit.sv
// Console serial line unit: receiver and transmitter status and buffer
// registers driven by bus reads, bus writes and ticks arriving as words on
// the input stream, one result word per input word. One word is taken every
// clock cycle while m_tready does not stall the result register; a word passes
// an input register, the register-file decode and a result register, which lets
// a new word enter while a finished result still waits. The user writes tx_delay
// through cfg_wr_en/cfg_wr_data only while the unit is idle; it is not enforced.
module console_serial_line_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // tx_delay
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // reg_sel, write_data, rx_valid, rx_char, zero fill
  input  logic [1:0]  s_tuser,       // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata        // read_data, rx_accepted, tx_valid, tx_char,
                                     // rx_irq, tx_irq, zero fill
);

  logic [cslu_pkg::DELAY_W-1:0] tx_delay;
  logic                         in_valid;
  cslu_pkg::item_t              in_item;
  cslu_pkg::result_t            core_res;
  cslu_pkg::result_t            out_res;
  logic                         advance;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_delay <= cslu_pkg::TX_DELAY_RESET;
    end else if (cfg_wr_en) begin
      tx_delay <= cfg_wr_data;
    end
  end

  // word moves on when the result register is free or being drained
  assign advance = in_valid && (!m_tvalid || m_tready);

  cslu_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .valid    (in_valid),
    .item     (in_item)
  );

  cslu_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .item     (in_item),
    .tx_delay (tx_delay),
    .res      (core_res)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  // pack output word
  assign m_tdata = {5'b0, out_res.tx_irq, out_res.rx_irq, out_res.tx_char,
                    out_res.tx_valid, out_res.rx_accepted, out_res.read_data};

  // receive interrupt only with a taken character
  a_rx_irq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!out_res.rx_irq || out_res.rx_accepted))
    else $error("rx irq without accepted character");

  // tick outputs never accompany read data
  a_read_only: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.read_data != '0) |->
    (!out_res.tx_valid && !out_res.rx_accepted && !out_res.tx_irq))
    else $error("read data mixed with tick outputs");

  // a new result is loaded only into a free or draining register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped");

endmodule

// File: rtl/cslu_in_stage.sv
// input register of the console serial line unit
module cslu_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // reg_sel, write_data, rx_valid, rx_char, zero fill
  input  logic [1:0]           s_tuser,   // cmd
  input  logic                 advance,
  output logic                 valid,
  output cslu_pkg::item_t      item
);

  // free slot when empty or when the held word moves on this cycle
  assign s_tready = !valid || advance;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.cmd        <= cslu_pkg::cmd_t'(s_tuser[1:0]);
      item.reg_sel    <= cslu_pkg::reg_t'(s_tdata[1:0]);
      item.write_data <= s_tdata[17:2];
      item.rx_valid   <= s_tdata[18];
      item.rx_char    <= s_tdata[26:19];
    end
  end

endmodule

// File: rtl/cslu_core.sv
// register file and command decode of the console serial line unit
module cslu_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  fire,
  input  cslu_pkg::item_t                       item,
  input  logic [cslu_pkg::DELAY_W-1:0]          tx_delay,
  output cslu_pkg::result_t                     res
);

  logic                          rx_done, rx_done_next;
  logic                          rx_int_enable, rx_int_enable_next;
  logic [cslu_pkg::CHAR_W-1:0]   rx_data, rx_data_next;
  logic                          tx_ready, tx_ready_next;
  logic                          tx_int_enable, tx_int_enable_next;
  logic                          tx_pending, tx_pending_next;
  logic [cslu_pkg::CHAR_W-1:0]   tx_data, tx_data_next;
  logic [cslu_pkg::DELAY_W-1:0]  tx_countdown, tx_countdown_next;
  logic [cslu_pkg::DELAY_W-1:0]  cd_base;

  // command decode and next state
  always_comb begin
    rx_done_next       = rx_done;
    rx_int_enable_next = rx_int_enable;
    rx_data_next       = rx_data;
    tx_ready_next      = tx_ready;
    tx_int_enable_next = tx_int_enable;
    tx_pending_next    = tx_pending;
    tx_data_next       = tx_data;
    tx_countdown_next  = tx_countdown;
    cd_base            = tx_countdown;
    res                = '0;
    case (item.cmd)
      cslu_pkg::CMD_READ: begin
        case (item.reg_sel)
          cslu_pkg::REG_RX_STATUS: begin
            res.read_data[cslu_pkg::DONE_BIT]   = rx_done;
            res.read_data[cslu_pkg::INT_EN_BIT] = rx_int_enable;
          end
          cslu_pkg::REG_RX_BUFFER: begin
            rx_done_next  = 1'b0;
            res.read_data = {{(cslu_pkg::DATA_W-cslu_pkg::CHAR_W){1'b0}}, rx_data};
          end
          cslu_pkg::REG_TX_STATUS: begin
            res.read_data[cslu_pkg::DONE_BIT]   = tx_ready;
            res.read_data[cslu_pkg::INT_EN_BIT] = tx_int_enable;
          end
          default: begin
            res.read_data = '0;
          end
        endcase
      end
      cslu_pkg::CMD_WRITE: begin
        case (item.reg_sel)
          cslu_pkg::REG_RX_STATUS: rx_int_enable_next = item.write_data[cslu_pkg::INT_EN_BIT];
          cslu_pkg::REG_RX_BUFFER: rx_done_next       = 1'b0;
          cslu_pkg::REG_TX_STATUS: tx_int_enable_next = item.write_data[cslu_pkg::INT_EN_BIT];
          default: begin
            tx_data_next    = item.write_data[cslu_pkg::CHAR_W-1:0];
            tx_pending_next = 1'b1;
            tx_ready_next   = 1'b0;
          end
        endcase
      end
      cslu_pkg::CMD_TICK: begin
        // receiver latch
        if (!rx_done && item.rx_valid) begin
          rx_data_next    = item.rx_char[cslu_pkg::CHAR_W-1:0];
          rx_done_next    = 1'b1;
          res.rx_accepted = 1'b1;
          res.rx_irq      = rx_int_enable;
        end
        // transmitter emit
        if (tx_pending) begin
          res.tx_valid    = 1'b1;
          res.tx_char     = tx_data;
          tx_pending_next = 1'b0;
          cd_base         = tx_delay;
        end
        tx_countdown_next = cd_base;
        // ready countdown
        if (!tx_ready) begin
          tx_countdown_next = cd_base - 1'b1;
          if (tx_countdown_next == '0) begin
            tx_ready_next = 1'b1;
            res.tx_irq    = tx_int_enable;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // state registers, updated when a word is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_done       <= 1'b0;
      rx_int_enable <= 1'b0;
      rx_data       <= '0;
      tx_ready      <= 1'b1;
      tx_int_enable <= 1'b0;
      tx_pending    <= 1'b0;
      tx_data       <= '0;
      tx_countdown  <= '0;
    end else if (fire) begin
      rx_done       <= rx_done_next;
      rx_int_enable <= rx_int_enable_next;
      rx_data       <= rx_data_next;
      tx_ready      <= tx_ready_next;
      tx_int_enable <= tx_int_enable_next;
      tx_pending    <= tx_pending_next;
      tx_data       <= tx_data_next;
      tx_countdown  <= tx_countdown_next;
    end
  end

  // a pending character always holds the transmitter busy
  a_pending_not_ready: assert property (@(posedge clk) disable iff (rst)
    tx_pending |-> !tx_ready)
    else $error("tx pending while tx ready");

  // a full receiver never takes another character
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (fire && rx_done && item.cmd == cslu_pkg::CMD_TICK) |-> !res.rx_accepted)
    else $error("character taken while rx done");

  // a tx buffer write leaves a pending character
  a_tx_write: assert property (@(posedge clk) disable iff (rst)
    (fire && item.cmd == cslu_pkg::CMD_WRITE && item.reg_sel == cslu_pkg::REG_TX_BUFFER)
    |=> (tx_pending && !tx_ready))
    else $error("tx buffer write lost");

endmodule

// File: tb/console_serial_line_unit_test.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the console serial line unit
module console_serial_line_unit_test;

  // command code outside the package enum, must be ignored by the unit
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned LATENCY = 2;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned STALL_LIMIT = 2000;

  // one bus word as the testbench keeps it
  typedef struct packed {
    logic [1:0]                  cmd;
    cslu_pkg::reg_t              reg_sel;
    logic [cslu_pkg::DATA_W-1:0] write_data;
    logic                        rx_valid;
    logic [7:0]                  rx_char;
  } bus_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  console_serial_line_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // words waiting to be sent and results still owed by the unit
  bus_word_t         bus_words[$];
  cslu_pkg::result_t owed_results[$];

  // traffic shaping, owned by the sequencing block
  bit                           gaps_on = 1'b0;
  bit                           stalls_on = 1'b0;
  int unsigned                  hold_asks = 0;
  logic [cslu_pkg::DELAY_W-1:0] tx_delay_cfg = cslu_pkg::TX_DELAY_RESET;

  int unsigned fail_count = 0;
  int unsigned result_count = 0;

  // predicted line state, owned by the driver
  logic                         line_rx_full, line_rx_ie, line_tx_idle, line_tx_ie;
  logic                         line_tx_queued;
  logic [cslu_pkg::CHAR_W-1:0]  line_rx_char, line_tx_char;
  logic [cslu_pkg::DELAY_W-1:0] line_tx_count;

  task automatic flag(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      flag($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                     result_count, name, got, want));
  endtask

  // apply one bus word to the predicted state and return its result
  function automatic cslu_pkg::result_t console_predict(input bus_word_t w);
    cslu_pkg::result_t r;
    r = '0;
    case (w.cmd)
      cslu_pkg::CMD_READ: begin
        case (w.reg_sel)
          cslu_pkg::REG_RX_STATUS: begin
            r.read_data[cslu_pkg::DONE_BIT]   = line_rx_full;
            r.read_data[cslu_pkg::INT_EN_BIT] = line_rx_ie;
          end
          cslu_pkg::REG_RX_BUFFER: begin
            line_rx_full = 1'b0;
            r.read_data[cslu_pkg::CHAR_W-1:0] = line_rx_char;
          end
          cslu_pkg::REG_TX_STATUS: begin
            r.read_data[cslu_pkg::DONE_BIT]   = line_tx_idle;
            r.read_data[cslu_pkg::INT_EN_BIT] = line_tx_ie;
          end
          default: ;
        endcase
      end
      cslu_pkg::CMD_WRITE: begin
        case (w.reg_sel)
          cslu_pkg::REG_RX_STATUS: line_rx_ie = w.write_data[cslu_pkg::INT_EN_BIT];
          cslu_pkg::REG_RX_BUFFER: line_rx_full = 1'b0;
          cslu_pkg::REG_TX_STATUS: line_tx_ie = w.write_data[cslu_pkg::INT_EN_BIT];
          default: begin
            line_tx_char   = w.write_data[cslu_pkg::CHAR_W-1:0];
            line_tx_queued = 1'b1;
            line_tx_idle   = 1'b0;
          end
        endcase
      end
      cslu_pkg::CMD_TICK: begin
        // receiver latches only while empty
        if (!line_rx_full && w.rx_valid) begin
          line_rx_char  = w.rx_char[cslu_pkg::CHAR_W-1:0];
          line_rx_full  = 1'b1;
          r.rx_accepted = 1'b1;
          r.rx_irq      = line_rx_ie;
        end
        // emit a queued character and start the ready countdown
        if (line_tx_queued) begin
          r.tx_valid     = 1'b1;
          r.tx_char      = line_tx_char;
          line_tx_queued = 1'b0;
          line_tx_count  = tx_delay_cfg;
        end
        // countdown wraps from zero, so a zero delay means 256 ticks
        if (!line_tx_idle) begin
          line_tx_count = line_tx_count - 8'd1;
          if (line_tx_count == '0) begin
            line_tx_idle = 1'b1;
            r.tx_irq     = line_tx_ie;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // gap lengths: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit on);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (!on || pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender: offers queued words, predicts each one as it is taken
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid       <= 1'b0;
      send_gap       = 0;
      line_rx_full   = 1'b0;
      line_rx_ie     = 1'b0;
      line_rx_char   = '0;
      line_tx_idle   = 1'b1;
      line_tx_ie     = 1'b0;
      line_tx_queued = 1'b0;
      line_tx_char   = '0;
      line_tx_count  = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        owed_results.push_back(console_predict(bus_words[0]));
        void'(bus_words.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (bus_words.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tuser  <= bus_words[0].cmd;
          s_tdata  <= {5'd0, bus_words[0].rx_char, bus_words[0].rx_valid,
                       bus_words[0].write_data, bus_words[0].reg_sel};
          send_gap = pick_gap(gaps_on);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result word and applies back-pressure
  int unsigned stall_left = 0;
  int unsigned holds_done = 0;
  always @(posedge clk) begin : receiver
    cslu_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          flag($sformatf("result word 0x%08h with nothing expected", m_tdata));
        end else begin
          want = owed_results.pop_front();
          check_field("read_data", m_tdata[15:0], want.read_data);
          check_field("rx_accepted", m_tdata[16], want.rx_accepted);
          check_field("tx_valid", m_tdata[17], want.tx_valid);
          check_field("tx_char", m_tdata[24:18], want.tx_char);
          check_field("rx_irq", m_tdata[25], want.rx_irq);
          check_field("tx_irq", m_tdata[26], want.tx_irq);
          check_field("zero fill", m_tdata[31:27], 0);
        end
        result_count++;
      end
      if (holds_done != hold_asks) begin
        holds_done++;
        stall_left = LONG_HOLD;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap(1'b1);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with work outstanding but no word moving
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (bus_words.size() == 0 && owed_results.size() == 0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d words unsent, %0d results owed",
                 bus_words.size(), owed_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic void put(input logic [1:0] cmd, input cslu_pkg::reg_t sel,
                              input logic [15:0] data, input logic valid,
                              input logic [7:0] ch);
    bus_word_t w;
    w.cmd        = cmd;
    w.reg_sel    = sel;
    w.write_data = data;
    w.rx_valid   = valid;
    w.rx_char    = ch;
    bus_words.push_back(w);
  endfunction

  function automatic cslu_pkg::reg_t any_reg();
    return cslu_pkg::reg_t'($urandom_range(0, 3));
  endfunction

  // random traffic: loose words mixed with receive and transmit exchanges
  function automatic void queue_traffic(input int unsigned count);
    int unsigned made, pick, ticks;
    logic [1:0]  cmd;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        pick = $urandom_range(0, 99);
        cmd = pick < 40 ? cslu_pkg::CMD_TICK : pick < 65 ? cslu_pkg::CMD_READ :
              pick < 95 ? cslu_pkg::CMD_WRITE : CMD_UNUSED;
        put(cmd, any_reg(), 16'($urandom), 1'($urandom), 8'($urandom));
        made++;
      end else if (pick < 8) begin
        // character arrives, software polls status then reads the buffer
        put(cslu_pkg::CMD_TICK, any_reg(), 16'($urandom), 1'b1, 8'($urandom));
        put(cslu_pkg::CMD_READ, cslu_pkg::REG_RX_STATUS, 16'($urandom), 1'($urandom),
            8'($urandom));
        put(cslu_pkg::CMD_READ, cslu_pkg::REG_RX_BUFFER, 16'($urandom), 1'($urandom),
            8'($urandom));
        made += 3;
      end else begin
        // software sends a character and waits for ready
        if ($urandom_range(0, 2) == 0) begin
          put(cslu_pkg::CMD_WRITE, cslu_pkg::REG_TX_STATUS, 16'($urandom), 1'($urandom),
              8'($urandom));
          made++;
        end
        put(cslu_pkg::CMD_WRITE, cslu_pkg::REG_TX_BUFFER, 16'($urandom), 1'($urandom),
            8'($urandom));
        ticks = $urandom_range(1, 6);
        repeat (ticks) put(cslu_pkg::CMD_TICK, any_reg(), 16'($urandom), 1'($urandom),
                           8'($urandom));
        put(cslu_pkg::CMD_READ, cslu_pkg::REG_TX_STATUS, 16'($urandom), 1'($urandom),
            8'($urandom));
        made += ticks + 2;
      end
    end
  endfunction

  // waits until every result is back, then lets the pipeline settle
  task automatic wait_drained();
    while (bus_words.size() != 0 || owed_results.size() != 0 || s_tvalid)
      @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic set_tx_delay(input logic [cslu_pkg::DELAY_W-1:0] value);
    @(posedge clk);
    cfg_wr_en    <= 1'b1;
    cfg_wr_data  <= value;
    tx_delay_cfg <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // phase sequencing
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset images, enables, receive overrun, NUL and overwrite
    put(cslu_pkg::CMD_READ, cslu_pkg::REG_RX_STATUS, 16'h0000, 1'b0, 8'h00);
    put(cslu_pkg::CMD_READ, cslu_pkg::REG_RX_BUFFER, 16'h0000, 1'b0, 8'h00);
    put(cslu_pkg::CMD_READ, cslu_pkg::REG_TX_STATUS, 16'h0000, 1'b0, 8'h00);
    put(cslu_pkg::CMD_READ, cslu_pkg::REG_TX_BUFFER, 16'hffff, 1'b1, 8'hff);
    put(cslu_pkg::CMD_WRITE, cslu_pkg::REG_RX_STATUS, 16'hffff, 1'b0, 8'h00);
    put(cslu_pkg::CMD_WRITE, cslu_pkg::REG_TX_STATUS, 16'h0040, 1'b0, 8'h00);
    put(cslu_pkg::CMD_TICK, cslu_pkg::REG_RX_STATUS, 16'h0000, 1'b1, 8'hff);
    put(cslu_pkg::CMD_TICK, cslu_pkg::REG_TX_BUFFER, 16'hffff, 1'b1, 8'h00);
    put(cslu_pkg::CMD_READ, cslu_pkg::REG_RX_STATUS, 16'h0000, 1'b0, 8'h00);
    put(cslu_pkg::CMD_READ, cslu_pkg::REG_RX_BUFFER, 16'h0000, 1'b0, 8'h00);
    put(cslu_pkg::CMD_TICK, cslu_pkg::REG_RX_BUFFER, 16'h0000, 1'b1, 8'h80);
    put(cslu_pkg::CMD_WRITE, cslu_pkg::REG_RX_BUFFER, 16'hffff, 1'b0, 8'h00);
    put(cslu_pkg::CMD_READ, cslu_pkg::REG_RX_BUFFER, 16'h0000, 1'b0, 8'h00);
    put(cslu_pkg::CMD_WRITE, cslu_pkg::REG_TX_BUFFER, 16'h0000, 1'b0, 8'h00);
    put(cslu_pkg::CMD_WRITE, cslu_pkg::REG_TX_BUFFER, 16'hffff, 1'b0, 8'h00);
    put(cslu_pkg::CMD_READ, cslu_pkg::REG_TX_STATUS, 16'h0000, 1'b0, 8'h00);
    put(cslu_pkg::CMD_TICK, cslu_pkg::REG_TX_STATUS, 16'h0000, 1'b0, 8'h00);
    put(CMD_UNUSED, cslu_pkg::REG_TX_BUFFER, 16'hffff, 1'b1, 8'hff);
    put(cslu_pkg::CMD_WRITE, cslu_pkg::REG_RX_STATUS, 16'hffbf, 1'b0, 8'h00);
    put(cslu_pkg::CMD_TICK, cslu_pkg::REG_RX_STATUS, 16'h0000, 1'b1, 8'h41);
    wait_drained();

    // shortest delay: ready and interrupt on the emission tick
    set_tx_delay(8'd1);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    put(cslu_pkg::CMD_WRITE, cslu_pkg::REG_TX_BUFFER, 16'h0000, 1'b0, 8'h00);
    put(cslu_pkg::CMD_TICK, cslu_pkg::REG_TX_BUFFER, 16'h0000, 1'b0, 8'h00);
    put(cslu_pkg::CMD_READ, cslu_pkg::REG_TX_STATUS, 16'h0000, 1'b0, 8'h00);
    put(cslu_pkg::CMD_WRITE, cslu_pkg::REG_TX_STATUS, 16'h0000, 1'b0, 8'h00);
    put(cslu_pkg::CMD_WRITE, cslu_pkg::REG_TX_BUFFER, 16'h0055, 1'b0, 8'h00);
    put(cslu_pkg::CMD_TICK, cslu_pkg::REG_TX_STATUS, 16'h0000, 1'b0, 8'h00);
    queue_traffic(95);
    wait_drained();

    // longest delay, with the receiver holding off while words pile up
    set_tx_delay(8'd255);
    queue_traffic(95);
    hold_asks++;
    wait_drained();

    // zero delay wraps to 256 ticks; no idling on either side
    set_tx_delay(8'd0);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    queue_traffic(95);
    wait_drained();

    set_tx_delay(8'($urandom_range(2, 12)));
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    queue_traffic(95);
    wait_drained();

    set_tx_delay(cslu_pkg::TX_DELAY_RESET);
    queue_traffic(95);
    wait_drained();
    repeat (LATENCY + 6) @(negedge clk);

    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cslu_pkg.sv
rtl/cslu_in_stage.sv
rtl/cslu_core.sv
rtl/console_serial_line_unit.sv
tb/console_serial_line_unit_test.sv
